// File: rtl/kcc_pkg.sv
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared types and constants for the key click classifier.
// ----------------------------------------------------------------------------
package kcc_pkg;

  localparam int LEVELS_W     = 3;
  localparam int TIME_W       = 32;
  localparam int CFG_W        = 16;
  localparam int COUNT_W      = 8;
  localparam int KIND_W       = 2;
  localparam int KEY_IDX_W    = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int NUM_KEYS_DEF = 3;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd10;
  localparam logic [CFG_W-1:0] DOUBLE_WIN_RST = 16'd300;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_RELEASED = 4'b0001,
    PH_CONFIRM  = 4'b0010,
    PH_PRESSED  = 4'b0100,
    PH_LONG     = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] double_click_window;
    logic [CFG_W-1:0] long_press_time;
  } cfg_t;

endpackage

// File: rtl/kcc_if.sv
// ----------------------------------------------------------------------------
// kcc_if
// Valid/ready channels for scan requests and classified results.
// ----------------------------------------------------------------------------
interface kcc_in_if;
  logic                           valid;
  logic                           ready;
  logic [kcc_pkg::LEVELS_W-1:0]   key_levels;
  logic [kcc_pkg::TIME_W-1:0]     now_ms;

  modport source (output valid, output key_levels, output now_ms, input ready);
  modport sink   (input valid, input key_levels, input now_ms, output ready);
endinterface

interface kcc_out_if;
  logic                           valid;
  logic                           ready;
  logic [kcc_pkg::KIND_W-1:0]     event_kind;
  logic [kcc_pkg::KEY_IDX_W-1:0]  key_index;

  modport source (output valid, output event_kind, output key_index, input ready);
  modport sink   (input valid, input event_kind, input key_index, output ready);
endinterface

// File: rtl/kcc_lane.sv
// ----------------------------------------------------------------------------
// kcc_lane
// Per-key debounce and click state machine with its own state registers.
// ----------------------------------------------------------------------------
module kcc_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          commit,
  input  logic                          down,
  input  logic [kcc_pkg::TIME_W-1:0]    now_ms,
  input  kcc_pkg::cfg_t                 cfg,
  output kcc_pkg::kind_t                ev
);

  kcc_pkg::phase_t                 phase_r, phase_nxt;
  logic [kcc_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic [kcc_pkg::TIME_W-1:0]      press_r, press_nxt;
  logic [kcc_pkg::TIME_W-1:0]      release_r, release_nxt;
  logic [kcc_pkg::TIME_W-1:0]      dp, dr;
  logic [kcc_pkg::TIME_W-1:0]      confirm_x, window_x, long_x;
  logic [kcc_pkg::COUNT_W-1:0]     count_inc;

  assign dp        = now_ms - press_r;
  assign dr        = now_ms - release_r;
  assign confirm_x = kcc_pkg::TIME_W'(cfg.debounce_ms);
  assign window_x  = kcc_pkg::TIME_W'(cfg.double_click_window);
  assign long_x    = kcc_pkg::TIME_W'(cfg.long_press_time);
  assign count_inc = count_r + 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    press_nxt   = press_r;
    release_nxt = release_r;
    ev          = kcc_pkg::EV_NONE;
    case (phase_r)
      kcc_pkg::PH_RELEASED: begin
        if (down) begin
          phase_nxt = kcc_pkg::PH_CONFIRM;
          press_nxt = now_ms;
        end else if ((count_r != '0) && (dr > window_x)) begin
          count_nxt = '0;
          ev        = kcc_pkg::EV_SINGLE;
        end
      end
      kcc_pkg::PH_CONFIRM: begin
        if (!down) begin
          phase_nxt = kcc_pkg::PH_RELEASED;
        end else if (dp > confirm_x) begin
          phase_nxt = kcc_pkg::PH_PRESSED;
        end
      end
      kcc_pkg::PH_PRESSED: begin
        if (!down) begin
          phase_nxt = kcc_pkg::PH_RELEASED;
          count_nxt = count_inc;
          if (count_inc == kcc_pkg::COUNT_W'(1)) begin
            release_nxt = now_ms;
          end else if (dr <= window_x) begin
            count_nxt = '0;
            ev        = kcc_pkg::EV_DOUBLE;
          end
        end else if (dp > long_x) begin
          phase_nxt = kcc_pkg::PH_LONG;
        end
      end
      kcc_pkg::PH_LONG: begin
        if (!down) begin
          phase_nxt = kcc_pkg::PH_RELEASED;
          ev        = kcc_pkg::EV_LONG;
        end
      end
      default: begin
        phase_nxt = kcc_pkg::PH_RELEASED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= kcc_pkg::PH_RELEASED;
      count_r <= '0;
    end else if (commit) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r   <= '0;
      release_r <= '0;
    end else if (commit) begin
      press_r   <= press_nxt;
      release_r <= release_nxt;
    end
  end

endmodule

// File: rtl/kcc_merge.sv
// ----------------------------------------------------------------------------
// kcc_merge
// Picks the lowest reporting key and gates which lanes advance this scan.
// ----------------------------------------------------------------------------
module kcc_merge #(
  parameter int NUM_KEYS = kcc_pkg::NUM_KEYS_DEF
) (
  input  logic                            accept,
  input  kcc_pkg::kind_t                  ev [NUM_KEYS],
  output logic [NUM_KEYS-1:0]             commit,
  output kcc_pkg::kind_t                  kind,
  output logic [kcc_pkg::KEY_IDX_W-1:0]   index
);

  logic found;

  always_comb begin
    found = 1'b0;
    kind  = kcc_pkg::EV_NONE;
    index = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      commit[k] = accept && !found;
      if (!found && (ev[k] != kcc_pkg::EV_NONE)) begin
        found = 1'b1;
        kind  = ev[k];
        index = kcc_pkg::KEY_IDX_W'(k);
      end
    end
  end

endmodule

// File: rtl/key_click_classifier_unit.sv
// ----------------------------------------------------------------------------
// key_click_classifier_unit
// Debounces active-low keys and reports single, double and long presses.
//
// Usage:
//   in_ch carries one scan request: raw key levels (0 = pressed) and the
//   current millisecond time. out_ch returns one result per request: the
//   event kind (none, single, double, long) and the reporting key index.
//   cfg_we/cfg_index/cfg_wdata write debounce time, double click window and
//   long press time; write them only while no request is in flight.
//   Every key has its own lane; the lowest reporting key wins and keys above
//   it keep their state for that scan.
// Timing:
//   One request per cycle while in_ch.ready is high. Results are registered
//   (in the skid register on a stall). The path is the per-lane 32-bit time
//   subtract and compare followed by the priority pick across the lanes.
// Reset and stall:
//   Reset puts every key in released with a zero click count and loads the
//   default times. When the receiver stalls, one more result goes to a skid
//   register; in_ch.ready drops only while that register is full.
// ----------------------------------------------------------------------------
module key_click_classifier_unit #(
  parameter int NUM_KEYS = kcc_pkg::NUM_KEYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [kcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kcc_pkg::CFG_W-1:0]       cfg_wdata,
  kcc_in_if.sink                          in_ch,
  kcc_out_if.source                       out_ch
);

  kcc_pkg::cfg_t                   cfg_r;
  kcc_pkg::kind_t                  ev [NUM_KEYS];
  logic [NUM_KEYS-1:0]             commit;
  kcc_pkg::kind_t                  m_kind;
  logic [kcc_pkg::KEY_IDX_W-1:0]   m_index;
  logic                            accept;
  logic                            out_fire;

  logic                            out_valid_r;
  kcc_pkg::kind_t                  out_kind_r;
  logic [kcc_pkg::KEY_IDX_W-1:0]   out_index_r;
  logic                            skid_valid_r;
  kcc_pkg::kind_t                  skid_kind_r;
  logic [kcc_pkg::KEY_IDX_W-1:0]   skid_index_r;

  assign in_ch.ready       = !skid_valid_r;
  assign accept            = in_ch.valid && !skid_valid_r;
  assign out_fire          = out_valid_r && out_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_kind = out_kind_r;
  assign out_ch.key_index  = out_index_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms         <= kcc_pkg::DEBOUNCE_RST;
      cfg_r.double_click_window <= kcc_pkg::DOUBLE_WIN_RST;
      cfg_r.long_press_time     <= kcc_pkg::LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        kcc_pkg::REG_DEBOUNCE:   cfg_r.debounce_ms         <= cfg_wdata;
        kcc_pkg::REG_DOUBLE_WIN: cfg_r.double_click_window <= cfg_wdata;
        kcc_pkg::REG_LONG_PRESS: cfg_r.long_press_time     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic down;
    if (k < kcc_pkg::LEVELS_W) begin : g_pin
      assign down = !in_ch.key_levels[k];
    end else begin : g_nopin
      assign down = 1'b1;
    end
    kcc_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .commit (commit[k]),
      .down   (down),
      .now_ms (in_ch.now_ms),
      .cfg    (cfg_r),
      .ev     (ev[k])
    );
  end

  kcc_merge #(.NUM_KEYS(NUM_KEYS)) u_merge (
    .accept (accept),
    .ev     (ev),
    .commit (commit),
    .kind   (m_kind),
    .index  (m_index)
  );

  // output register plus skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r  <= skid_valid_r || accept;
      skid_valid_r <= 1'b0;
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_kind_r  <= skid_kind_r;
        out_index_r <= skid_index_r;
      end else begin
        out_kind_r  <= m_kind;
        out_index_r <= m_index;
      end
    end else if (accept) begin
      skid_kind_r  <= m_kind;
      skid_index_r <= m_index;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output register is empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && out_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("request taken during stall was not parked in skid");

  a_none_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    (m_kind == kcc_pkg::EV_NONE) |-> (m_index == '0))
    else $error("key index nonzero without an event");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (m_kind != kcc_pkg::EV_NONE)) |-> (32'(m_index) < NUM_KEYS))
    else $error("reporting key index out of range");

  a_fire_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !skid_valid_r && !accept) |=> !out_valid_r)
    else $error("output stayed valid after its result was taken");

endmodule
